// ===== rtl/conv3x3_saturating_filter_assert.svh =====
// Assertion macros for the 3x3 filter checker.
`ifndef CONV3X3_SATURATING_FILTER_ASSERT_SVH
`define CONV3X3_SATURATING_FILTER_ASSERT_SVH

// same-cycle implication
`define C3SF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c3sf assertion failed");

// next-cycle implication
`define C3SF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c3sf assertion failed");

`endif

// ===== rtl/c3sf_pkg.sv =====
// Package of constants and types for the 3x3 saturating filter.
package c3sf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;
  localparam int KSIZE      = 3;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int KROW_W     = 24;
  localparam int COEF_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WCMP_W     = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;

  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int SUM_W      = RSUM_W + 2;
  localparam int PIX_MAX    = 255;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [KROW_W-1:0] krow_t;
  typedef krow_t [KSIZE-1:0] kernel_t;
  typedef pix_t [KSIZE-1:0]  column_t;
  // [row][tap], tap 0 is the oldest column
  typedef pix_t [KSIZE-1:0][KSIZE-1:0] window_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } lb_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MIDDLE = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_reg_e;

endpackage

// ===== rtl/c3sf_if.sv =====
// Handshake interfaces for pixel items, result items and configuration writes.
interface c3sf_pix_if;
  import c3sf_pkg::*;
  logic       valid;
  logic       ready;
  pix_t       pixel_value;
  logic       frame_start;
  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface c3sf_res_if;
  import c3sf_pkg::*;
  logic             valid;
  logic             ready;
  pix_t             filtered_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_column;
  logic             last_of_frame;
  modport source (output valid, filtered_value, out_row, out_column, last_of_frame,
                  input ready);
  modport sink   (input valid, filtered_value, out_row, out_column, last_of_frame,
                  output ready);
endinterface

interface c3sf_cfg_if;
  import c3sf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/c3sf_line_ram.sv =====
// Two-row line buffer RAM, one read and one write port, registered read with bypass.
module c3sf_line_ram (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [c3sf_pkg::ADDR_W-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [c3sf_pkg::ADDR_W-1:0] wr_addr_i,
  input  c3sf_pkg::lb_word_t       wr_data_i,
  output c3sf_pkg::lb_word_t       rd_data_o
);
  import c3sf_pkg::*;

  lb_word_t mem_q [MAX_WIDTH];
  lb_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= (wr_en_i && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/c3sf_window.sv =====
// Window registers holding the two previous columns of the 3x3 neighbourhood.
module c3sf_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  c3sf_pkg::column_t column_i,
  output c3sf_pkg::window_t window_o
);
  import c3sf_pkg::*;

  column_t [KSIZE-2:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= column_i;
    end
  end

  always_comb begin
    for (int t = 0; t < KSIZE; t++) begin
      window_o[t][0] = win_q[0][t];
      window_o[t][1] = win_q[1][t];
      window_o[t][2] = column_i[t];
    end
  end

endmodule

// ===== rtl/c3sf_mac.sv =====
// Multiply, row-sum, total and clamp pipeline feeding the result register.
module c3sf_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c3sf_pkg::window_t window_i,
  input  c3sf_pkg::kernel_t kernel_i,
  input  c3sf_pkg::meta_t   meta_i,
  c3sf_res_if.source        res
);
  import c3sf_pkg::*;

  logic signed [PROD_W-1:0] prod_d [KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod_q [KSIZE][KSIZE];
  logic signed [RSUM_W-1:0] rsum_d [KSIZE];
  logic signed [RSUM_W-1:0] rsum_q [KSIZE];
  logic signed [SUM_W-1:0]  sum_d;
  pix_t                     value_d;
  pix_t                     value_q;
  meta_t                    meta_p_q;
  meta_t                    meta_r_q;
  meta_t                    meta_o_q;
  logic                     vp_q;
  logic                     vr_q;
  logic                     vo_q;
  logic                     en_p;
  logic                     en_r;
  logic                     en_o;

  assign en_o       = !vo_q || res.ready;
  assign en_r       = !vr_q || en_o;
  assign en_p       = !vp_q || en_r;
  assign in_ready_o = en_p;

  always_comb begin
    for (int t = 0; t < KSIZE; t++) begin
      for (int k = 0; k < KSIZE; k++) begin
        prod_d[t][k] = PROD_W'($signed({1'b0, window_i[t][k]})) *
                       PROD_W'($signed(kernel_i[t][COEF_W*k +: COEF_W]));
      end
    end
  end

  always_comb begin
    for (int t = 0; t < KSIZE; t++) begin
      rsum_d[t] = RSUM_W'(prod_q[t][0]) + RSUM_W'(prod_q[t][1]) + RSUM_W'(prod_q[t][2]);
    end
  end

  always_comb begin
    sum_d = SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
    if (sum_d[SUM_W-1]) begin
      value_d = '0;
    end else if (sum_d > PIX_MAX) begin
      value_d = PIX_W'(PIX_MAX);
    end else begin
      value_d = sum_d[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vr_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_p) vp_q <= in_valid_i;
      if (en_r) vr_q <= vp_q;
      if (en_o) vo_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p && in_valid_i) begin
      prod_q   <= prod_d;
      meta_p_q <= meta_i;
    end
    if (en_r && vp_q) begin
      rsum_q   <= rsum_d;
      meta_r_q <= meta_p_q;
    end
    if (en_o && vr_q) begin
      value_q  <= value_d;
      meta_o_q <= meta_r_q;
    end
  end

  assign res.valid          = vo_q;
  assign res.filtered_value = value_q;
  assign res.out_row        = meta_o_q.row;
  assign res.out_column     = meta_o_q.col;
  assign res.last_of_frame  = meta_o_q.last;

endmodule

// ===== rtl/conv3x3_saturating_filter.sv =====
// Top level of the streaming 3x3 convolution filter with clamping to 0..255.
//
//   channel  dir  payload                                          handshake
//   pix_i    in   pixel_value, frame_start                         valid/ready
//   res_o    out  filtered_value, out_row, out_column, last_of_frame valid/ready
//   cfg_i    in   index, data (kernel rows, image width, height)    valid/ready
//
// One pixel item per cycle sustained while results are taken; the line buffer
// RAM is read on accept and written as the pixel leaves stage 1, bypassed when
// both touch the same entry; a result passes stage 1 and the MAC pipeline.
// Reset clears counters, window and pipeline valids; the RAM is not cleared.
// A stalled output fills up to four pipeline slots before pix_i.ready drops.
module conv3x3_saturating_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  c3sf_pix_if.sink   pix_i,
  c3sf_res_if.source res_o,
  c3sf_cfg_if.sink   cfg_i
);
  import c3sf_pkg::*;

  kernel_t              kernel_q;
  logic [WIDTH_W-1:0]   width_q;
  logic [HEIGHT_W-1:0]  height_q;
  logic [WCMP_W-1:0]    w_eff;
  logic [HEIGHT_W-1:0]  h_eff;

  logic [ADDR_W-1:0]    col_cnt_q;
  logic [ADDR_W-1:0]    col_cnt_d;
  logic [ROW_W-1:0]     row_cnt_q;
  logic [ROW_W-1:0]     row_cnt_d;
  logic [ADDR_W-1:0]    c0;
  logic [ROW_W-1:0]     r0;
  logic                 col_end;
  logic                 row_end;
  meta_t                meta0;
  logic                 prod0;

  logic                 s1_v_q;
  pix_t                 s1_px_q;
  logic [ADDR_W-1:0]    s1_idx_q;
  logic                 s1_prod_q;
  meta_t                s1_meta_q;

  logic                 en1;
  logic                 accept;
  logic                 leave1;
  logic                 mac_ready;
  lb_word_t             rd_data;
  lb_word_t             wr_data;
  column_t              column;
  window_t              window;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0] <= '0;
      kernel_q[1] <= KROW_W'(256);
      kernel_q[2] <= '0;
      width_q     <= WIDTH_W'(640);
      height_q    <= HEIGHT_W'(480);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_KERNEL_TOP:    kernel_q[0] <= cfg_i.data[KROW_W-1:0];
        CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg_i.data[KROW_W-1:0];
        CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_i.data[KROW_W-1:0];
        CFG_IMAGE_WIDTH:   width_q     <= cfg_i.data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q    <= cfg_i.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (WCMP_W'(width_q) < WCMP_W'(MIN_SIZE)) begin
      w_eff = WCMP_W'(MIN_SIZE);
    end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(width_q);
    end
    if (height_q < HEIGHT_W'(MIN_SIZE)) begin
      h_eff = HEIGHT_W'(MIN_SIZE);
    end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign en1    = !s1_v_q || mac_ready;
  assign accept = pix_i.valid && en1;
  assign leave1 = s1_v_q && mac_ready;
  assign pix_i.ready = en1;

  always_comb begin
    c0        = pix_i.frame_start ? '0 : col_cnt_q;
    r0        = pix_i.frame_start ? '0 : row_cnt_q;
    col_end   = (WCMP_W'(c0) + WCMP_W'(1)) >= w_eff;
    row_end   = (HEIGHT_W'(r0) + HEIGHT_W'(1)) >= h_eff;
    prod0     = (r0 >= ROW_W'(2)) && (c0 >= ADDR_W'(2));
    meta0.row  = r0 - ROW_W'(1);
    meta0.col  = COL_W'(c0) - COL_W'(1);
    meta0.last = ((HEIGHT_W'(r0) + HEIGHT_W'(1)) == h_eff) &&
                 ((WCMP_W'(c0) + WCMP_W'(1)) == w_eff);
    if (col_end) begin
      col_cnt_d = '0;
      row_cnt_d = row_end ? '0 : r0 + ROW_W'(1);
    end else begin
      col_cnt_d = c0 + ADDR_W'(1);
      row_cnt_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      s1_v_q    <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      if (en1) s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pix_i.pixel_value;
      s1_idx_q  <= c0;
      s1_prod_q <= prod0;
      s1_meta_q <= meta0;
    end
  end

  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = s1_px_q;

  assign column[0] = rd_data.older;
  assign column[1] = rd_data.newer;
  assign column[2] = s1_px_q;

  c3sf_line_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c0),
    .wr_en_i   (leave1),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  c3sf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (leave1),
    .column_i (column),
    .window_o (window)
  );

  c3sf_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_v_q && s1_prod_q),
    .in_ready_o (mac_ready),
    .window_i   (window),
    .kernel_i   (kernel_q),
    .meta_i     (s1_meta_q),
    .res        (res_o)
  );

endmodule

// ===== rtl/c3sf_checker.sv =====
// Port-level checker for the 3x3 filter, bound to the top level.
`include "conv3x3_saturating_filter_assert.svh"

module c3sf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input c3sf_pkg::pix_t               res_value_i,
  input logic [c3sf_pkg::ROW_W-1:0]   res_row_i,
  input logic [c3sf_pkg::COL_W-1:0]   res_column_i,
  input logic                         res_last_i,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_i
);
  import c3sf_pkg::*;

  `C3SF_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_value_i) && $stable(res_row_i) && $stable(res_column_i) && $stable(res_last_i))
  `C3SF_ASSERT_IMP(a_row_interior, res_valid_i, (res_row_i != '0) && (res_row_i != '1))
  `C3SF_ASSERT_IMP(a_col_interior, res_valid_i, (res_column_i != '0) && (res_column_i != '1))
  `C3SF_ASSERT_IMP(a_cfg_always_ready, cfg_valid_i, cfg_ready_i)

endmodule

bind conv3x3_saturating_filter c3sf_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_value_i  (res_o.filtered_value),
  .res_row_i    (res_o.out_row),
  .res_column_i (res_o.out_column),
  .res_last_i   (res_o.last_of_frame),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);

// ===== sim/conv3x3_saturating_filter_tb.sv =====
// Self-checking testbench for the streaming 3x3 saturating convolution filter.
`timescale 1ns / 1ps

module conv3x3_saturating_filter_tb;
  import c3sf_pkg::*;

  typedef struct packed {
    pix_t value;
    logic frame_start;
  } pixel_item_t;

  typedef struct packed {
    pix_t  value;
    meta_t where;
  } filter_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  pix_valid       = 1'b0;
  pix_t                  pix_value       = '0;
  logic                  pix_frame_start = 1'b0;
  logic                  res_ready       = 1'b0;
  logic                  cfg_valid       = 1'b0;
  cfg_reg_e              cfg_index       = CFG_KERNEL_TOP;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  pixel_item_t    pixel_q[$];
  filter_result_t expected_q[$];
  int unsigned    pushed   = 0;
  int unsigned    accepted = 0;
  int unsigned    errors   = 0;
  int unsigned    cycle_no = 0;
  logic           steady;

  // shadow of the filter state
  krow_t               kern [KSIZE]     = '{24'h000000, 24'h000100, 24'h000000};
  logic [WIDTH_W-1:0]  width_reg        = WIDTH_W'(640);
  logic [HEIGHT_W-1:0] height_reg       = HEIGHT_W'(480);
  pix_t                lb_old [MAX_WIDTH] = '{default: '0};
  pix_t                lb_new [MAX_WIDTH] = '{default: '0};
  pix_t                win [6]          = '{default: '0};
  int unsigned         col_pos          = 0;
  int unsigned         row_pos          = 0;

  c3sf_pix_if pix ();
  c3sf_res_if res ();
  c3sf_cfg_if cfg ();

  assign pix.valid       = pix_valid;
  assign pix.pixel_value = pix_value;
  assign pix.frame_start = pix_frame_start;
  assign res.ready       = res_ready;
  assign cfg.valid       = cfg_valid;
  assign cfg.index       = cfg_index;
  assign cfg.data        = cfg_data;

  conv3x3_saturating_filter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // no random stalls on either side in this stretch
  assign steady = (cycle_no >= 500) && (cycle_no < 900);

  function automatic void write_shadow(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_KERNEL_TOP:    kern[0] = d;
      CFG_KERNEL_MIDDLE: kern[1] = d;
      CFG_KERNEL_BOTTOM: kern[2] = d;
      CFG_IMAGE_WIDTH:   width_reg = d[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT:  height_reg = d[HEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit convolve_pixel(input pix_t px, input logic fs,
                                        output filter_result_t out_item);
    int unsigned w, h, c, r, idx, t;
    pix_t        column [KSIZE];
    int          acc;
    bit          hit;
    w = width_reg;
    if (w < MIN_SIZE) w = MIN_SIZE;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < MIN_SIZE) h = MIN_SIZE;
    else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    idx = c % MAX_WIDTH;
    column[0] = lb_old[idx];
    column[1] = lb_new[idx];
    column[2] = px;
    out_item = '0;
    hit = (r >= 2) && (c >= 2);
    if (hit) begin
      acc = 0;
      for (t = 0; t < KSIZE; t++) begin
        acc += int'(win[t])     * int'($signed(kern[t][7:0]));
        acc += int'(win[3 + t]) * int'($signed(kern[t][15:8]));
        acc += int'(column[t])  * int'($signed(kern[t][23:16]));
      end
      out_item.value = (acc < 0) ? pix_t'(0) : (acc > PIX_MAX) ? pix_t'(PIX_MAX) : pix_t'(acc);
      out_item.where.row  = ROW_W'(r - 1);
      out_item.where.col  = COL_W'(c - 1);
      out_item.where.last = (r + 1 == h) && (c + 1 == w);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = column[0];
    win[4] = column[1];
    win[5] = column[2];
    lb_old[idx] = column[1];
    lb_new[idx] = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_item_t it;
    if (!rst_ni) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix.ready) begin
      if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
        it = pixel_q.pop_front();
        pix_valid       <= 1'b1;
        pix_value       <= it.value;
        pix_frame_start <= it.frame_start;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_ready <= 1'b0;
    else res_ready <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin : result_check
    filter_result_t want, got;
    if (rst_ni) begin
      if (cfg_valid && cfg.ready) write_shadow(cfg_index, cfg_data);
      if (pix_valid && pix.ready) begin
        accepted++;
        if (convolve_pixel(pix_value, pix_frame_start, want)) expected_q.push_back(want);
      end
      if (res.valid && res_ready) begin
        got.value      = res.filtered_value;
        got.where.row  = res.out_row;
        got.where.col  = res.out_column;
        got.where.last = res.last_of_frame;
        if (expected_q.size() == 0) begin
          $display("%0t: expected no result, got value %0d row %0d column %0d last %0b",
                   $time, got.value, got.where.row, got.where.col, got.where.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("filtered_value", want.value, got.value);
          check_field("out_row", want.where.row, got.where.row);
          check_field("out_column", want.where.col, got.where.col);
          check_field("last_of_frame", want.where.last, got.where.last);
        end
      end
    end
  end

  function automatic pix_t pick_pixel();
    case ($urandom_range(7))
      0: return pix_t'(0);
      1: return pix_t'(PIX_MAX);
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic krow_t random_krow();
    krow_t       k;
    int unsigned i;
    case ($urandom_range(5))
      0: k = krow_t'($urandom);
      1: k = {3{8'h7f}};
      2: k = {3{8'h80}};
      default: begin
        for (i = 0; i < KSIZE; i++) k[8 * i +: 8] = 8'(int'($urandom_range(4)) - 2);
      end
    endcase
    return k;
  endfunction

  task automatic queue_pixel(input pix_t v, input logic fs);
    pixel_item_t it;
    it.value = v;
    it.frame_start = fs;
    pixel_q.push_back(it);
    pushed++;
  endtask

  // stray_pct: chance of a frame start inside the run
  task automatic push_pixels(input int unsigned n, input bit first_fs,
                             input int unsigned stray_pct);
    int unsigned i;
    for (i = 0; i < n; i++)
      queue_pixel(pick_pixel(), (i == 0) ? first_fs : ($urandom_range(99) < stray_pct));
  endtask

  task automatic push_flat_image(input bit fs, input pix_t top, input pix_t mid,
                                 input pix_t bot);
    int unsigned i;
    for (i = 0; i < 9; i++)
      queue_pixel((i < 3) ? top : (i < 6) ? mid : bot, fs && (i == 0));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input krow_t top, input krow_t mid, input krow_t bot,
                           input int unsigned w, input int unsigned h);
    write_reg(CFG_KERNEL_TOP, top);
    write_reg(CFG_KERNEL_MIDDLE, mid);
    write_reg(CFG_KERNEL_BOTTOM, bot);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  // wait for all items and results, then for the pipeline to empty
  task automatic drain();
    while (accepted != pushed || expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned w, h, ew, eh, sz, img, n_img, start;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // settings after reset: 640 wide, stays in the first row
    push_pixels(40, 1'b1, 0);
    drain();

    // identity kernel from reset over a 64 wide image; fills the line buffer entries in use
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(64));
    push_pixels(3 * 64, 1'b1, 0);
    drain();

    // smallest image, sizes below range; saturation both ways, wrap without frame start
    configure({3{8'h7f}}, {3{8'h80}}, {3{8'h01}}, 0, 2);
    push_flat_image(1'b1, 8'd255, 8'd0, 8'd0);
    push_flat_image(1'b0, 8'd0, 8'd255, 8'd0);
    push_pixels(2, 1'b1, 0);
    push_flat_image(1'b1, 8'd0, 8'd0, 8'd80);
    drain();

    // width and height above range
    configure(random_krow(), random_krow(), random_krow(), 2047, 8191);
    push_pixels(100, 1'b1, 0);
    drain();

    // sizes changed part way through an image
    configure(random_krow(), random_krow(), random_krow(), 8, 12);
    push_pixels(3 * 8 + 6, 1'b1, 0);
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
    push_pixels(14, 1'b0, 0);
    drain();
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    push_pixels(11, 1'b0, 0);
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(10));
    push_pixels(40, 1'b0, 0);
    drain();

    start = pushed;
    while (pushed - start < 900) begin
      case ($urandom_range(19))
        0, 1:    w = $urandom_range(2);
        2, 3, 4: w = $urandom_range(40, 13);
        default: w = $urandom_range(12, 3);
      endcase
      case ($urandom_range(19))
        0, 1:    h = $urandom_range(2);
        2, 3, 4: h = $urandom_range(20, 9);
        default: h = $urandom_range(8, 3);
      endcase
      ew = (w < MIN_SIZE) ? MIN_SIZE : w;
      eh = (h < MIN_SIZE) ? MIN_SIZE : h;
      sz = ew * eh;
      configure(random_krow(), random_krow(), random_krow(), w, h);
      n_img = $urandom_range(3, 1);
      for (img = 0; img < n_img; img++) begin
        case ($urandom_range(9))
          0:       push_pixels($urandom_range(sz - 1, 1), 1'b1, 0);
          1:       push_pixels(sz, 1'b0, 0);
          2:       push_pixels(sz, 1'b1, 3);
          default: push_pixels(sz, 1'b1, 0);
        endcase
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
